// ===== rtl/qwlm_pkg.sv =====
// ----------------------------------------------------------------------------
// qwlm_pkg
// Shared types, constants and helpers of the queue wait light monitor.
// ----------------------------------------------------------------------------
package qwlm_pkg;

    localparam int OCCUPANCY_MAX = 255;
    localparam int TIMER_BITS    = 16;

    localparam int OCC_W   = $clog2(OCCUPANCY_MAX + 1);
    localparam int WAIT_W  = 12;
    localparam int SPP_W   = 4;
    localparam int LIMIT_W = 12;
    localparam int IVL_W   = 16;
    localparam int DEB_W   = 10;
    localparam int CMP_W   = (TIMER_BITS > IVL_W) ? TIMER_BITS : IVL_W;
    localparam int PROD_W  = OCC_W + SPP_W;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_APPROVAL_INTERVAL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECONDS_PER_PERSON = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTENTION_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LIMIT        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HYSTERESIS_MARGIN  = 3'd5;

    localparam logic [IVL_W-1:0]   RST_APPROVAL_INTERVAL  = 16'd2000;
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE_TICKS     = 10'd40;
    localparam logic [SPP_W-1:0]   RST_SECONDS_PER_PERSON = 4'd2;
    localparam logic [LIMIT_W-1:0] RST_ATTENTION_LIMIT    = 12'd15;
    localparam logic [LIMIT_W-1:0] RST_BLOCK_LIMIT        = 12'd30;
    localparam logic [LIMIT_W-1:0] RST_HYSTERESIS_MARGIN  = 12'd7;

    typedef logic [1:0] t_light;
    localparam t_light LIGHT_FREE      = 2'd0;
    localparam t_light LIGHT_ATTENTION = 2'd1;
    localparam t_light LIGHT_BLOCKED   = 2'd2;

    typedef logic [1:0] t_best;
    localparam t_best BEST_A     = 2'd0;
    localparam t_best BEST_B     = 2'd1;
    localparam t_best BEST_EQUAL = 2'd2;

    typedef struct packed {
        logic [IVL_W-1:0]   approval_interval;
        logic [DEB_W-1:0]   debounce_ticks;
        logic [SPP_W-1:0]   seconds_per_person;
        logic [LIMIT_W-1:0] attention_limit;
        logic [LIMIT_W-1:0] block_limit;
        logic [LIMIT_W-1:0] hysteresis_margin;
    } t_cfg;

    typedef struct packed {
        logic [OCC_W-1:0] occupancy;
        logic             activity;
    } t_q_upd;

    function automatic logic [WAIT_W-1:0] f_wait(
        input logic [OCC_W-1:0] occ,
        input logic [SPP_W-1:0] spp
    );
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(occ) * PROD_W'(spp);
        if (prod > PROD_W'(WAIT_MAX)) begin
            f_wait = WAIT_MAX;
        end else begin
            f_wait = prod[WAIT_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/queue_wait_light_monitor.sv =====
// ----------------------------------------------------------------------------
// queue_wait_light_monitor
// Two-queue arrival counter with approval timers and wait lights.
// ----------------------------------------------------------------------------
// Path: a request waits in the input register, which feeds the tick logic; the
//   tick logic loads the result register once it is empty or being read.
// Throughput: one request per cycle while i_ready stays high; the tick logic
//   is a single pass between the input register and the result register.
// Reset: synchronous, active low; clears queue state, lights, valids and
//   restores the configuration defaults.
module queue_wait_light_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_button_a_level,
    input  logic                                i_button_b_level,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_light_a,
    output logic [1:0]                          o_light_b,
    output logic [qwlm_pkg::OCC_W-1:0]          o_people_a,
    output logic [qwlm_pkg::OCC_W-1:0]          o_people_b,
    output logic [qwlm_pkg::WAIT_W-1:0]         o_wait_a,
    output logic [qwlm_pkg::WAIT_W-1:0]         o_wait_b,
    output logic [1:0]                          o_best_queue,
    output logic                                o_changed,
    input  logic                                i_cfg_wr_en,
    input  logic [qwlm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [qwlm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    qwlm_pkg::t_cfg r_cfg;

    logic r_in_valid;
    logic r_lvl_a;
    logic r_lvl_b;
    logic r_out_valid;

    qwlm_pkg::t_light              r_light_a;
    qwlm_pkg::t_light              r_light_b;
    logic [qwlm_pkg::OCC_W-1:0]    r_people_a;
    logic [qwlm_pkg::OCC_W-1:0]    r_people_b;
    logic [qwlm_pkg::WAIT_W-1:0]   r_wait_a;
    logic [qwlm_pkg::WAIT_W-1:0]   r_wait_b;
    qwlm_pkg::t_best               r_best;
    logic                          r_changed;

    logic                          advance;
    logic                          accept;
    logic                          changed_any;
    qwlm_pkg::t_q_upd              upd_a;
    qwlm_pkg::t_q_upd              upd_b;
    logic [qwlm_pkg::WAIT_W-1:0]   n_wait_a;
    logic [qwlm_pkg::WAIT_W-1:0]   n_wait_b;
    qwlm_pkg::t_light              n_light_a;
    qwlm_pkg::t_light              n_light_b;
    qwlm_pkg::t_best               n_best;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.approval_interval  <= qwlm_pkg::RST_APPROVAL_INTERVAL;
            r_cfg.debounce_ticks     <= qwlm_pkg::RST_DEBOUNCE_TICKS;
            r_cfg.seconds_per_person <= qwlm_pkg::RST_SECONDS_PER_PERSON;
            r_cfg.attention_limit    <= qwlm_pkg::RST_ATTENTION_LIMIT;
            r_cfg.block_limit        <= qwlm_pkg::RST_BLOCK_LIMIT;
            r_cfg.hysteresis_margin  <= qwlm_pkg::RST_HYSTERESIS_MARGIN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                qwlm_pkg::CFG_APPROVAL_INTERVAL:
                    r_cfg.approval_interval <= i_cfg_wdata[qwlm_pkg::IVL_W-1:0];
                qwlm_pkg::CFG_DEBOUNCE_TICKS:
                    r_cfg.debounce_ticks <= i_cfg_wdata[qwlm_pkg::DEB_W-1:0];
                qwlm_pkg::CFG_SECONDS_PER_PERSON:
                    r_cfg.seconds_per_person <= i_cfg_wdata[qwlm_pkg::SPP_W-1:0];
                qwlm_pkg::CFG_ATTENTION_LIMIT:
                    r_cfg.attention_limit <= i_cfg_wdata[qwlm_pkg::LIMIT_W-1:0];
                qwlm_pkg::CFG_BLOCK_LIMIT:
                    r_cfg.block_limit <= i_cfg_wdata[qwlm_pkg::LIMIT_W-1:0];
                qwlm_pkg::CFG_HYSTERESIS_MARGIN:
                    r_cfg.hysteresis_margin <= i_cfg_wdata[qwlm_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // hold the request until the tick logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lvl_a <= i_button_a_level;
            r_lvl_b <= i_button_b_level;
        end
    end

    qwlm_queue u_queue_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_level   (r_lvl_a),
        .i_cfg     (r_cfg),
        .o_upd     (upd_a)
    );

    qwlm_queue u_queue_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_level   (r_lvl_b),
        .i_cfg     (r_cfg),
        .o_upd     (upd_b)
    );

    assign changed_any = upd_a.activity || upd_b.activity;
    assign n_wait_a    = qwlm_pkg::f_wait(upd_a.occupancy, r_cfg.seconds_per_person);
    assign n_wait_b    = qwlm_pkg::f_wait(upd_b.occupancy, r_cfg.seconds_per_person);

    qwlm_light u_light_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_changed (changed_any),
        .i_wait    (n_wait_a),
        .i_cfg     (r_cfg),
        .o_light   (n_light_a)
    );

    qwlm_light u_light_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_changed (changed_any),
        .i_wait    (n_wait_b),
        .i_cfg     (r_cfg),
        .o_light   (n_light_b)
    );

    always_comb begin
        priority if (n_wait_a == n_wait_b) n_best = qwlm_pkg::BEST_EQUAL;
        else if (n_wait_b < n_wait_a)      n_best = qwlm_pkg::BEST_B;
        else                               n_best = qwlm_pkg::BEST_A;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_light_a  <= n_light_a;
            r_light_b  <= n_light_b;
            r_people_a <= upd_a.occupancy;
            r_people_b <= upd_b.occupancy;
            r_wait_a   <= n_wait_a;
            r_wait_b   <= n_wait_b;
            r_best     <= n_best;
            r_changed  <= changed_any;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_light_a    = r_light_a;
    assign o_light_b    = r_light_b;
    assign o_people_a   = r_people_a;
    assign o_people_b   = r_people_b;
    assign o_wait_a     = r_wait_a;
    assign o_wait_b     = r_wait_b;
    assign o_best_queue = r_best;
    assign o_changed    = r_changed;

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("pending request dropped from input register");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_wait_a)
                                       && $stable(r_best)))
        else $error("stalled result overwritten");

    a_best_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_best == qwlm_pkg::BEST_EQUAL) == (r_wait_a == r_wait_b)))
        else $error("best queue disagrees with waits");

    a_light_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_light_a != 2'd3) && (r_light_b != 2'd3)))
        else $error("light code out of range");

endmodule

// ===== rtl/qwlm_queue.sv =====
// ----------------------------------------------------------------------------
// qwlm_queue
// One queue: button debounce, arrival count, approval timer, occupancy.
// ----------------------------------------------------------------------------
module qwlm_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_level,
    input  qwlm_pkg::t_cfg              i_cfg,
    output qwlm_pkg::t_q_upd            o_upd
);

    localparam logic [qwlm_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [qwlm_pkg::OCC_W-1:0] OCC_MAX =
        qwlm_pkg::OCC_W'(qwlm_pkg::OCCUPANCY_MAX);

    logic                            r_last;
    logic                            r_settled;
    logic [qwlm_pkg::TIMER_BITS-1:0] r_age;
    logic [qwlm_pkg::TIMER_BITS-1:0] r_elapsed;
    logic [qwlm_pkg::OCC_W-1:0]      r_occ;

    logic                            n_settled;
    logic [qwlm_pkg::TIMER_BITS-1:0] n_age;
    logic [qwlm_pkg::TIMER_BITS-1:0] n_elapsed;
    logic [qwlm_pkg::OCC_W-1:0]      n_occ;

    logic                            settle;
    logic                            arrival;
    logic                            slot;
    logic                            approve;
    logic [qwlm_pkg::TIMER_BITS-1:0] age_eff;
    logic [qwlm_pkg::TIMER_BITS-1:0] elapsed_eff;
    logic [qwlm_pkg::OCC_W-1:0]      occ_arr;

    always_comb begin
        age_eff = (i_level != r_last) ? '0 : r_age;
        settle  = (qwlm_pkg::CMP_W'(age_eff) >= qwlm_pkg::CMP_W'(i_cfg.debounce_ticks))
                  && (i_level != r_settled);
        arrival = settle && !i_level;
        occ_arr = (arrival && (r_occ != OCC_MAX)) ? r_occ + 1'b1 : r_occ;

        slot        = qwlm_pkg::CMP_W'(r_elapsed)
                      >= qwlm_pkg::CMP_W'(i_cfg.approval_interval);
        approve     = slot && (occ_arr != '0);
        elapsed_eff = slot ? '0 : r_elapsed;

        n_occ     = approve ? occ_arr - 1'b1 : occ_arr;
        n_settled = settle ? i_level : r_settled;
        n_age     = (age_eff == TIMER_MAX) ? age_eff : age_eff + 1'b1;
        n_elapsed = (elapsed_eff == TIMER_MAX) ? elapsed_eff : elapsed_eff + 1'b1;

        o_upd.occupancy = n_occ;
        o_upd.activity  = arrival || approve;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= 1'b1;
            r_settled <= 1'b1;
            r_age     <= '0;
            r_elapsed <= '0;
            r_occ     <= '0;
        end else if (i_advance) begin
            r_last    <= i_level;
            r_settled <= n_settled;
            r_age     <= n_age;
            r_elapsed <= n_elapsed;
            r_occ     <= n_occ;
        end
    end

endmodule

// ===== rtl/qwlm_light.sv =====
// ----------------------------------------------------------------------------
// qwlm_light
// Light state of one queue with hysteresis between free, attention, blocked.
// ----------------------------------------------------------------------------
module qwlm_light (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic                         i_changed,
    input  logic [qwlm_pkg::WAIT_W-1:0]  i_wait,
    input  qwlm_pkg::t_cfg               i_cfg,
    output qwlm_pkg::t_light             o_light
);

    localparam int S_W = qwlm_pkg::LIMIT_W + 2;

    qwlm_pkg::t_light r_light;
    qwlm_pkg::t_light n_light;
    qwlm_pkg::t_light cls;

    logic signed [S_W-1:0] s_wait;
    logic signed [S_W-1:0] s_att;
    logic signed [S_W-1:0] s_blk;
    logic signed [S_W-1:0] s_down_free;
    logic signed [S_W-1:0] s_down_att;

    always_comb begin
        s_wait      = $signed(S_W'(i_wait));
        s_att       = $signed(S_W'(i_cfg.attention_limit));
        s_blk       = $signed(S_W'(i_cfg.block_limit));
        s_down_free = s_att - $signed(S_W'(i_cfg.hysteresis_margin));
        s_down_att  = s_blk - $signed(S_W'(i_cfg.hysteresis_margin));

        unique case (r_light)
            qwlm_pkg::LIGHT_BLOCKED: begin
                priority if (s_wait <= s_down_free) cls = qwlm_pkg::LIGHT_FREE;
                else if (s_wait <= s_down_att)      cls = qwlm_pkg::LIGHT_ATTENTION;
                else                                cls = qwlm_pkg::LIGHT_BLOCKED;
            end
            qwlm_pkg::LIGHT_ATTENTION: begin
                priority if (s_wait > s_blk)     cls = qwlm_pkg::LIGHT_BLOCKED;
                else if (s_wait <= s_down_free)  cls = qwlm_pkg::LIGHT_FREE;
                else                             cls = qwlm_pkg::LIGHT_ATTENTION;
            end
            default: begin
                priority if (s_wait > s_blk) cls = qwlm_pkg::LIGHT_BLOCKED;
                else if (s_wait > s_att)     cls = qwlm_pkg::LIGHT_ATTENTION;
                else                         cls = qwlm_pkg::LIGHT_FREE;
            end
        endcase

        n_light = i_changed ? cls : r_light;
        o_light = n_light;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= qwlm_pkg::LIGHT_FREE;
        end else if (i_advance) begin
            r_light <= n_light;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the two-queue wait light monitor. Button ticks are sent
// through the request channel while an in-bench model tracks debounce,
// arrivals, approvals, occupancy, waits and the hysteresis lights. Every
// returned status is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import qwlm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        t_light            light_a;
        t_light            light_b;
        logic [OCC_W-1:0]  people_a;
        logic [OCC_W-1:0]  people_b;
        logic [WAIT_W-1:0] wait_a;
        logic [WAIT_W-1:0] wait_b;
        t_best             best_queue;
        logic              changed;
    } t_status;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   i_button_a_level = 1'b1;
    logic                   i_button_b_level = 1'b1;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [1:0]             o_light_a;
    logic [1:0]             o_light_b;
    logic [OCC_W-1:0]       o_people_a;
    logic [OCC_W-1:0]       o_people_b;
    logic [WAIT_W-1:0]      o_wait_a;
    logic [WAIT_W-1:0]      o_wait_b;
    logic [1:0]             o_best_queue;
    logic                   o_changed;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_APPROVAL_INTERVAL;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    queue_wait_light_monitor dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_button_a_level (i_button_a_level),
        .i_button_b_level (i_button_b_level),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_light_a        (o_light_a),
        .o_light_b        (o_light_b),
        .o_people_a       (o_people_a),
        .o_people_b       (o_people_b),
        .o_wait_a         (o_wait_a),
        .o_wait_b         (o_wait_b),
        .o_best_queue     (o_best_queue),
        .o_changed        (o_changed),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // monitor model state
    t_cfg                  cfg;
    logic                  last_lvl [2];
    logic                  settled_lvl [2];
    logic [TIMER_BITS-1:0] level_age [2];
    logic [TIMER_BITS-1:0] since_approval [2];
    logic [OCC_W-1:0]      people [2];
    t_light                light [2];

    t_status status_due [$];
    int      error_count = 0;
    int      status_seen = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [WAIT_W-1:0] wait_secs(logic [OCC_W-1:0] n);
        int prod;
        prod = int'(n) * int'(cfg.seconds_per_person);
        if (prod > int'(WAIT_MAX)) return WAIT_MAX;
        return WAIT_W'(prod);
    endfunction

    function automatic t_light next_light(t_light cur, logic [WAIT_W-1:0] secs);
        int w;
        int att;
        int blk;
        int down_free;
        int down_att;
        w         = int'(secs);
        att       = int'(cfg.attention_limit);
        blk       = int'(cfg.block_limit);
        down_free = att - int'(cfg.hysteresis_margin);
        down_att  = blk - int'(cfg.hysteresis_margin);
        case (cur)
            LIGHT_BLOCKED: begin
                if (w <= down_free) return LIGHT_FREE;
                if (w <= down_att) return LIGHT_ATTENTION;
                return LIGHT_BLOCKED;
            end
            LIGHT_ATTENTION: begin
                if (w > blk) return LIGHT_BLOCKED;
                if (w <= down_free) return LIGHT_FREE;
                return LIGHT_ATTENTION;
            end
            default: begin
                if (w > blk) return LIGHT_BLOCKED;
                if (w > att) return LIGHT_ATTENTION;
                return LIGHT_FREE;
            end
        endcase
    endfunction

    task automatic compute_status(input logic lvl_a, input logic lvl_b);
        logic              lvl [2];
        logic              activity;
        logic [WAIT_W-1:0] secs [2];
        t_status           s;
        lvl[0]   = lvl_a;
        lvl[1]   = lvl_b;
        activity = 1'b0;
        for (int q = 0; q < 2; q++) begin
            if (lvl[q] != last_lvl[q]) begin
                level_age[q] = '0;
                last_lvl[q]  = lvl[q];
            end
            if (level_age[q] >= cfg.debounce_ticks && lvl[q] != settled_lvl[q]) begin
                settled_lvl[q] = lvl[q];
                if (!lvl[q]) begin
                    if (people[q] < OCCUPANCY_MAX) people[q] = people[q] + 1'b1;
                    activity = 1'b1;
                end
            end
            if (since_approval[q] >= cfg.approval_interval) begin
                since_approval[q] = '0;
                if (people[q] != '0) begin
                    people[q] = people[q] - 1'b1;
                    activity  = 1'b1;
                end
            end
        end
        for (int q = 0; q < 2; q++) begin
            secs[q] = wait_secs(people[q]);
            if (activity) light[q] = next_light(light[q], secs[q]);
        end
        s.light_a  = light[0];
        s.light_b  = light[1];
        s.people_a = people[0];
        s.people_b = people[1];
        s.wait_a   = secs[0];
        s.wait_b   = secs[1];
        if (secs[0] == secs[1]) s.best_queue = BEST_EQUAL;
        else if (secs[1] < secs[0]) s.best_queue = BEST_B;
        else s.best_queue = BEST_A;
        s.changed = activity;
        status_due.push_back(s);
        for (int q = 0; q < 2; q++) begin
            if (level_age[q] != '1) level_age[q] = level_age[q] + 1'b1;
            if (since_approval[q] != '1) since_approval[q] = since_approval[q] + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("ERROR status %0d: %s", status_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : status_check
        t_status want;
        if (i_rst_n && o_valid && i_ready) begin
            if (status_due.size() == 0) begin
                report_mismatch("status with no request pending");
            end else begin
                want = status_due.pop_front();
                check_field("light_a", 16'(o_light_a), 16'(want.light_a));
                check_field("light_b", 16'(o_light_b), 16'(want.light_b));
                check_field("people_a", 16'(o_people_a), 16'(want.people_a));
                check_field("people_b", 16'(o_people_b), 16'(want.people_b));
                check_field("wait_a", 16'(o_wait_a), 16'(want.wait_a));
                check_field("wait_b", 16'(o_wait_b), 16'(want.wait_b));
                check_field("best_queue", 16'(o_best_queue), 16'(want.best_queue));
                check_field("changed", 16'(o_changed), 16'(want.changed));
            end
            status_seen++;
        end
    end

    task automatic send_tick(input logic lvl_a, input logic lvl_b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_button_a_level <= lvl_a;
        i_button_b_level <= lvl_b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        compute_status(lvl_a, lvl_b);
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input int value,
                           input int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] data;
        keep = CFG_DATA_W'((1 << width) - 1);
        data = (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // upper data bits carry noise; an unused index is written last
    task automatic apply_config(input int ivl, input int deb, input int spp,
                                input int att, input int blk, input int mgn);
        wait_drained();
        put_reg(CFG_APPROVAL_INTERVAL, ivl, IVL_W);
        put_reg(CFG_DEBOUNCE_TICKS, deb, DEB_W);
        put_reg(CFG_SECONDS_PER_PERSON, spp, SPP_W);
        put_reg(CFG_ATTENTION_LIMIT, att, LIMIT_W);
        put_reg(CFG_BLOCK_LIMIT, blk, LIMIT_W);
        put_reg(CFG_HYSTERESIS_MARGIN, mgn, LIMIT_W);
        put_reg(CFG_INDEX_W'($urandom_range(2 ** CFG_INDEX_W - 1,
                CFG_HYSTERESIS_MARGIN + 1)), $urandom, CFG_DATA_W);
        i_cfg_wr_en            <= 1'b0;
        cfg.approval_interval  = IVL_W'(ivl);
        cfg.debounce_ticks     = DEB_W'(deb);
        cfg.seconds_per_person = SPP_W'(spp);
        cfg.attention_limit    = LIMIT_W'(att);
        cfg.block_limit        = LIMIT_W'(blk);
        cfg.hysteresis_margin  = LIMIT_W'(mgn);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // presses and releases held past the debounce time, with a given share of
    // bounces of random length that may or may not outlast it
    task automatic run_button_traffic(input int n, input int extra, input int bounce_pct);
        logic lvl [2];
        int   left [2];
        int   deb;
        deb = int'(cfg.debounce_ticks);
        for (int q = 0; q < 2; q++) begin
            lvl[q]  = 1'b1;
            left[q] = $urandom_range(deb + 1, 0);
        end
        repeat (n) begin
            for (int q = 0; q < 2; q++) begin
                if (left[q] <= 0) begin
                    lvl[q] = !lvl[q];
                    if ($urandom_range(99) < bounce_pct) left[q] = $urandom_range(deb + 1, 1);
                    else left[q] = deb + 1 + $urandom_range(extra);
                end
            end
            send_tick(lvl[0], lvl[1]);
            left[0]--;
            left[1]--;
        end
    endtask

    task automatic test_directed_edges;
        set_idling(27, 70);
        // approval every tick cancels a simultaneous arrival
        apply_config(0, 0, 15, 0, 20, 4095);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        // margin above the limits: lights only rise
        apply_config(65535, 1, 15, 0, 20, 4095);
        repeat (2) send_tick(1'b0, 1'b1);
        repeat (2) send_tick(1'b1, 1'b1);
        repeat (2) send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        repeat (2) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        // inverted limits, zero rate, longest debounce
        apply_config(1, 1023, 0, 4095, 0, 0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    task automatic test_default_timing;
        apply_config(RST_APPROVAL_INTERVAL, RST_DEBOUNCE_TICKS, RST_SECONDS_PER_PERSON,
                     RST_ATTENTION_LIMIT, RST_BLOCK_LIMIT, RST_HYSTERESIS_MARGIN);
        run_button_traffic(150, 3, 10);
    endtask

    task automatic test_random_lights;
        set_idling(70, 27);
        repeat (3) begin
            apply_config($urandom_range(20, 2), $urandom_range(3), $urandom_range(15, 1),
                         $urandom_range(60), $urandom_range(90), $urandom_range(25));
            run_button_traffic(110, 3, 20);
        end
    endtask

    task automatic test_occupancy_ceiling;
        set_idling(0, 0);
        apply_config(65535, 0, 15, 1000, 3000, 500);
        run_button_traffic(620, 0, 0);
    endtask

    task automatic test_drain_extremes;
        apply_config(1, 1023, 15, 4095, 4095, 0);
        run_button_traffic(50, 2, 50);
    endtask

    initial begin
        cfg.approval_interval  = RST_APPROVAL_INTERVAL;
        cfg.debounce_ticks     = RST_DEBOUNCE_TICKS;
        cfg.seconds_per_person = RST_SECONDS_PER_PERSON;
        cfg.attention_limit    = RST_ATTENTION_LIMIT;
        cfg.block_limit        = RST_BLOCK_LIMIT;
        cfg.hysteresis_margin  = RST_HYSTERESIS_MARGIN;
        for (int q = 0; q < 2; q++) begin
            last_lvl[q]       = 1'b1;
            settled_lvl[q]    = 1'b1;
            level_age[q]      = '0;
            since_approval[q] = '0;
            people[q]         = '0;
            light[q]          = LIGHT_FREE;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_default_timing();
        test_random_lights();
        test_occupancy_ceiling();
        test_drain_extremes();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qwlm_pkg.sv
rtl/qwlm_queue.sv
rtl/qwlm_light.sv
rtl/queue_wait_light_monitor.sv
verif/tb_top.sv
